// ===== rtl/ects_pkg.sv =====
// Shared constants and tempo/key tier functions for the energy curve transition search unit.
// No dependencies; imported by the unit RTL and the testbench.
`timescale 1ns / 1ps
package ects_pkg;

	localparam int EnergyW = 16;
	localparam int OpW     = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;
	localparam int PitchW  = 4;
	localparam int ScoreW  = 14;
	localparam int IndexW  = 10;
	localparam int TimeW   = 26;
	localparam int CompW   = 16;

	localparam logic [OpW-1:0] OpLoadFirst  = 2'd0;
	localparam logic [OpW-1:0] OpLoadSecond = 2'd1;
	localparam logic [OpW-1:0] OpEvaluate   = 2'd2;

	localparam logic [CfgIdxW-1:0] RegTempoFirst   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegTempoSecond  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPitchFirst   = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPitchSecond  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegWindowFirst  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegWindowSecond = 3'd5;

	localparam logic [PitchW-1:0] PitchUnknown = 4'd12;
	localparam logic [CompW-1:0]  QOne         = 16'd32768;
	localparam logic [CompW-1:0]  QHalf        = 16'd16384;

	localparam logic [CompW-1:0] TempoTier0 = 16'd32768;
	localparam logic [CompW-1:0] TempoTier1 = 16'd22938;
	localparam logic [CompW-1:0] TempoTier2 = 16'd13107;
	localparam logic [CompW-1:0] TempoTier3 = 16'd4915;

	localparam logic [CompW-1:0] KeySame    = 16'd32768;
	localparam logic [CompW-1:0] KeyFifth   = 16'd27853;
	localparam logic [CompW-1:0] KeyThird   = 16'd24576;
	localparam logic [CompW-1:0] KeyTritone = 16'd6554;
	localparam logic [CompW-1:0] KeyStep    = 16'd19661;
	localparam logic [CompW-1:0] KeyOther   = 16'd13107;

	localparam logic [ScoreW-1:0] ScoreMax = 14'd10000;

	// floor(y/5) = (y * Recip5) >> Recip5Shift for y below 2^18
	localparam logic [17:0] Recip5      = 18'd209716;
	localparam int          Recip5Shift = 20;
	localparam logic [9:0]  Thousand    = 10'd1000;

	function automatic logic [CompW-1:0] tempo_tier(input logic [CfgW-1:0] a,
			input logic [CfgW-1:0] b);
		logic [CfgW-1:0] d;
		logic [CfgW:0]   s;
		logic [23:0]     d200;
		logic [20:0]     s3, s6, s10;
		logic [CompW-1:0] t;
		d    = (a > b) ? a - b : b - a;
		s    = {1'b0, a} + {1'b0, b};
		d200 = ({8'd0, d} << 7) + ({8'd0, d} << 6) + ({8'd0, d} << 3);
		s3   = ({4'd0, s} << 1) + {4'd0, s};
		s6   = s3 << 1;
		s10  = ({4'd0, s} << 3) + ({4'd0, s} << 1);
		if (a == '0 || b == '0) t = QHalf;
		else if (d200 <= {3'd0, s3}) t = TempoTier0;
		else if (d200 <= {3'd0, s6}) t = TempoTier1;
		else if (d200 <= {3'd0, s10}) t = TempoTier2;
		else t = TempoTier3;
		return t;
	endfunction

	function automatic logic [CompW-1:0] key_tier(input logic [PitchW-1:0] a,
			input logic [PitchW-1:0] b);
		logic [PitchW-1:0] d;
		logic [CompW-1:0]  k;
		d = (a > b) ? a - b : b - a;
		if (a > 4'd11 || b > 4'd11) k = QHalf;
		else begin
			case (d)
				4'd0: k = KeySame;
				4'd5, 4'd7: k = KeyFifth;
				4'd3, 4'd9: k = KeyThird;
				4'd6: k = KeyTritone;
				4'd1, 4'd11: k = KeyStep;
				default: k = KeyOther;
			endcase
		end
		return k;
	endfunction

endpackage

// ===== rtl/ects_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ects_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/energy_curve_transition_search_unit.sv =====
// Loads samples of curve A and B, then on evaluate finds the best window pair
// and one overall transition score. An evaluate request keeps busy high while
// it runs the shared 16-step normalizing divider over every sample and the
// single multiplier twice per window pair. The result appears for one cycle
// with done high and must be taken then; an evaluate with an empty curve or a
// zero window length gives an all-zero result in the next cycle.
// Depends on ects_pkg and ects_ram.
`timescale 1ns / 1ps
module energy_curve_transition_search_unit #(
	parameter int MAX_WINDOWS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ects_pkg::OpW-1:0]         operation,
	input  logic [ects_pkg::EnergyW-1:0]     energy,
	input  logic                             wr_en,
	input  logic [ects_pkg::CfgIdxW-1:0]     wr_index,
	input  logic [ects_pkg::CfgW-1:0]        wr_data,
	output logic                             done,
	output logic [ects_pkg::ScoreW-1:0]      score,
	output logic [ects_pkg::IndexW-1:0]      index_first,
	output logic [ects_pkg::IndexW-1:0]      index_second,
	output logic [ects_pkg::TimeW-1:0]       time_first_ms,
	output logic [ects_pkg::TimeW-1:0]       time_second_ms,
	output logic [ects_pkg::CompW-1:0]       tempo_component,
	output logic [ects_pkg::CompW-1:0]       key_component,
	output logic [ects_pkg::CompW-1:0]       energy_component
);
	import ects_pkg::*;

	localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CW = $clog2(MAX_WINDOWS + 1);
	localparam int MA = 19;
	localparam int MB = 18;
	localparam int MP = MA + MB;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_BRD  = 5'd1;
	localparam logic [4:0] S_BWT  = 5'd2;
	localparam logic [4:0] S_BDIV = 5'd3;
	localparam logic [4:0] S_BWR  = 5'd4;
	localparam logic [4:0] S_ARD  = 5'd5;
	localparam logic [4:0] S_AWT  = 5'd6;
	localparam logic [4:0] S_ADIV = 5'd7;
	localparam logic [4:0] S_AFIN = 5'd8;
	localparam logic [4:0] S_NRD  = 5'd9;
	localparam logic [4:0] S_NWT  = 5'd10;
	localparam logic [4:0] S_M2   = 5'd11;
	localparam logic [4:0] S_CMP  = 5'd12;
	localparam logic [4:0] S_EY   = 5'd13;
	localparam logic [4:0] S_EC   = 5'd14;
	localparam logic [4:0] S_SC   = 5'd15;
	localparam logic [4:0] S_T1   = 5'd16;
	localparam logic [4:0] S_T2   = 5'd17;

	logic [4:0] state_q;

	logic [CfgW-1:0]   tempo_first_q, tempo_second_q, win_first_q, win_second_q;
	logic [PitchW-1:0] pitch_first_q, pitch_second_q;

	logic [CW-1:0]      cnt_a_q, cnt_b_q, i_q, j_q;
	logic [EnergyW-1:0] min_a_q, max_a_q, min_b_q, max_b_q;

	logic [16:0] div_r_q;
	logic [15:0] div_d_q, div_q_q;
	logic [3:0]  step_q;
	logic [15:0] prev_q, low_q, fall_q, rise_q;
	logic [31:0] p1_q, p2_q;
	logic [32:0] best_q;
	logic [AW-1:0] bi_q, bj_q;
	logic [17:0] y_q;
	logic [CompW-1:0] tc_q, kc_q, ec_q;

	logic                done_q;
	logic                eval_done_q;
	logic [ScoreW-1:0]   score_q;
	logic [TimeW-1:0]    time1_q, time2_q;

	logic accept, full_a, full_b, we_a, we_b, we_n, eval_ok;
	logic [EnergyW-1:0] rd_a, rd_b;
	logic [31:0]        rd_n;
	logic [MA-1:0]      mul_a;
	logic [MB-1:0]      mul_b;
	logic [MP-1:0]      mul_p;
	logic               div_ge;
	logic [16:0]        div_rn;
	logic [15:0]        cur_rise, cur_fall;
	logic [32:0]        pair_s;
	logic [33:0]        ey_sum;
	logic [18:0]        tot_sum;
	logic [16:0]        ec_raw;
	logic [MP:0]        sc_sum;
	logic [MP-15:0]     sc_raw;
	logic [MA+AW-1:0]   bi_ext, bj_ext;
	logic [IndexW+AW-1:0] bi_idx, bj_idx;

	assign accept  = start && !busy;
	assign full_a  = cnt_a_q >= CW'(MAX_WINDOWS);
	assign full_b  = cnt_b_q >= CW'(MAX_WINDOWS);
	assign we_a    = accept && operation == OpLoadFirst && !full_a;
	assign we_b    = accept && operation == OpLoadSecond && !full_b;
	assign we_n    = state_q == S_BWR;
	assign eval_ok = cnt_a_q != '0 && cnt_b_q != '0 && win_first_q != '0 &&
		win_second_q != '0;

	ects_ram #(.WIDTH(EnergyW), .DEPTH(MAX_WINDOWS)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(cnt_a_q[AW-1:0]), .wdata(energy),
		.raddr(i_q[AW-1:0]), .rdata(rd_a)
	);

	ects_ram #(.WIDTH(EnergyW), .DEPTH(MAX_WINDOWS)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(cnt_b_q[AW-1:0]), .wdata(energy),
		.raddr(j_q[AW-1:0]), .rdata(rd_b)
	);

	ects_ram #(.WIDTH(32), .DEPTH(MAX_WINDOWS)) u_ram_n (
		.clk(clk), .we(we_n), .waddr(j_q[AW-1:0]), .wdata({div_q_q, cur_rise}),
		.raddr(j_q[AW-1:0]), .rdata(rd_n)
	);

	assign div_ge   = div_r_q >= {1'b0, div_d_q};
	assign div_rn   = div_ge ? div_r_q - {1'b0, div_d_q} : div_r_q;
	assign cur_rise = (j_q != '0 && div_q_q > prev_q) ? div_q_q - prev_q : '0;
	assign cur_fall = (i_q != '0 && prev_q > div_q_q) ? prev_q - div_q_q : '0;
	assign pair_s   = {1'b0, p1_q} + {p1_q, 1'b0} + {p2_q, 1'b0};
	assign ey_sum   = {1'b0, best_q} + 34'd81920;
	assign tot_sum  = {1'b0, tc_q, 2'b00} + {3'd0, kc_q} + {2'd0, kc_q, 1'b0} +
		{3'd0, ec_q} + {2'd0, ec_q, 1'b0};
	assign ec_raw   = mul_p[Recip5Shift+16:Recip5Shift];
	assign sc_sum   = {1'b0, mul_p} + (MP+1)'(16384);
	assign sc_raw   = sc_sum[MP:15];
	assign bi_ext   = {{MA{1'b0}}, bi_q};
	assign bj_ext   = {{MA{1'b0}}, bj_q};
	assign bi_idx   = {{IndexW{1'b0}}, bi_q};
	assign bj_idx   = {{IndexW{1'b0}}, bj_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_NWT: begin
				mul_a = {3'd0, low_q};
				mul_b = {2'd0, rd_n[31:16]};
			end
			S_M2: begin
				mul_a = {3'd0, fall_q};
				mul_b = {2'd0, rise_q};
			end
			S_EC: begin
				mul_a = {1'b0, y_q};
				mul_b = Recip5;
			end
			S_SC: begin
				mul_a = tot_sum;
				mul_b = {8'd0, Thousand};
			end
			S_T1: begin
				mul_a = bi_ext[MA-1:0];
				mul_b = {2'd0, win_first_q};
			end
			S_T2: begin
				mul_a = bj_ext[MA-1:0];
				mul_b = {2'd0, win_second_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {{MB{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_first_q  <= '0;
			tempo_second_q <= '0;
			pitch_first_q  <= PitchUnknown;
			pitch_second_q <= PitchUnknown;
			win_first_q    <= '0;
			win_second_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				RegTempoFirst:   tempo_first_q  <= wr_data;
				RegTempoSecond:  tempo_second_q <= wr_data;
				RegPitchFirst:   pitch_first_q  <= wr_data[PitchW-1:0];
				RegPitchSecond:  pitch_second_q <= wr_data[PitchW-1:0];
				RegWindowFirst:  win_first_q    <= wr_data;
				RegWindowSecond: win_second_q   <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (we_a) cnt_a_q <= cnt_a_q + 1'b1;
					if (we_b) cnt_b_q <= cnt_b_q + 1'b1;
					if (accept && operation == OpEvaluate) begin
						i_q <= '0;
						j_q <= '0;
						if (eval_ok) state_q <= S_BRD;
						else begin
							done_q  <= 1'b1;
							cnt_a_q <= '0;
							cnt_b_q <= '0;
						end
					end
				end
				S_BRD:  state_q <= S_BWT;
				S_BWT:  state_q <= S_BDIV;
				S_BDIV: if (step_q == '0) state_q <= S_BWR;
				S_BWR: begin
					if (j_q + 1'b1 == cnt_b_q) begin
						j_q     <= '0;
						state_q <= S_ARD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_BRD;
					end
				end
				S_ARD:  state_q <= S_AWT;
				S_AWT:  state_q <= S_ADIV;
				S_ADIV: if (step_q == '0) state_q <= S_AFIN;
				S_AFIN: begin
					j_q     <= '0;
					state_q <= S_NRD;
				end
				S_NRD:  state_q <= S_NWT;
				S_NWT:  state_q <= S_M2;
				S_M2:   state_q <= S_CMP;
				S_CMP: begin
					if (j_q + 1'b1 == cnt_b_q) begin
						j_q <= '0;
						if (i_q + 1'b1 == cnt_a_q) state_q <= S_EY;
						else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_ARD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_NRD;
					end
				end
				S_EY: state_q <= S_EC;
				S_EC: state_q <= S_SC;
				S_SC: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: begin
					done_q  <= 1'b1;
					cnt_a_q <= '0;
					cnt_b_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (we_a) begin
					if (cnt_a_q == '0 || energy < min_a_q) min_a_q <= energy;
					if (cnt_a_q == '0 || energy > max_a_q) max_a_q <= energy;
				end
				if (we_b) begin
					if (cnt_b_q == '0 || energy < min_b_q) min_b_q <= energy;
					if (cnt_b_q == '0 || energy > max_b_q) max_b_q <= energy;
				end
				if (accept && operation == OpEvaluate) begin
					tc_q    <= tempo_tier(tempo_first_q, tempo_second_q);
					kc_q    <= key_tier(pitch_first_q, pitch_second_q);
					best_q  <= '0;
					bi_q    <= '0;
					bj_q    <= '0;
					ec_q    <= '0;
					score_q <= '0;
					time1_q <= '0;
					time2_q <= '0;
				end
			end
			S_BWT: begin
				step_q  <= 4'd15;
				div_q_q <= '0;
				if (max_b_q > min_b_q) begin
					div_r_q <= {1'b0, rd_b - min_b_q};
					div_d_q <= max_b_q - min_b_q;
				end else begin
					div_r_q <= '0;
					div_d_q <= 16'd1;
				end
			end
			S_AWT: begin
				step_q  <= 4'd15;
				div_q_q <= '0;
				if (max_a_q > min_a_q) begin
					div_r_q <= {1'b0, rd_a - min_a_q};
					div_d_q <= max_a_q - min_a_q;
				end else begin
					div_r_q <= '0;
					div_d_q <= 16'd1;
				end
			end
			S_BDIV, S_ADIV: begin
				div_q_q <= {div_q_q[14:0], div_ge};
				div_r_q <= {div_rn[15:0], 1'b0};
				step_q  <= step_q - 1'b1;
			end
			S_BWR: prev_q <= div_q_q;
			S_AFIN: begin
				fall_q <= cur_fall;
				low_q  <= QOne - div_q_q;
				prev_q <= div_q_q;
			end
			S_NWT: begin
				p1_q   <= mul_p[31:0];
				rise_q <= rd_n[15:0];
			end
			S_M2: p2_q <= mul_p[31:0];
			S_CMP: begin
				if (pair_s > best_q) begin
					best_q <= pair_s;
					bi_q   <= i_q[AW-1:0];
					bj_q   <= j_q[AW-1:0];
				end
			end
			S_EY: y_q <= ey_sum[32:15];
			S_EC: ec_q <= (ec_raw > {1'b0, QOne}) ? QOne : ec_raw[15:0];
			S_SC: score_q <= (sc_raw > (MP-14)'(ScoreMax)) ? ScoreMax :
				sc_raw[ScoreW-1:0];
			S_T1: time1_q <= mul_p[TimeW-1:0];
			S_T2: time2_q <= mul_p[TimeW-1:0];
			default: ;
		endcase
	end

	assign busy             = state_q != S_IDLE;
	assign done             = done_q;
	assign score            = score_q;
	assign index_first      = bi_idx[IndexW-1:0];
	assign index_second     = bj_idx[IndexW-1:0];
	assign time_first_ms    = time1_q;
	assign time_second_ms   = time2_q;
	assign tempo_component  = (score_q == '0 && ec_q == '0 && time1_q == '0 &&
		time2_q == '0 && bi_q == '0 && bj_q == '0 && !eval_done_q) ? '0 : tc_q;
	assign key_component    = (score_q == '0 && ec_q == '0 && time1_q == '0 &&
		time2_q == '0 && bi_q == '0 && bj_q == '0 && !eval_done_q) ? '0 : kc_q;
	assign energy_component = ec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eval_done_q <= 1'b0;
		else if (accept && operation == OpEvaluate) eval_done_q <= eval_ok;
	end

endmodule

// ===== test/tb.sv =====
// Self-checking bench for energy_curve_transition_search_unit: directed table, a full store,
// then random load/evaluate sequences checked against a behavioral score predictor.
// Depends on ects_pkg and the unit RTL.
`timescale 1ns / 1ps
module tb;
	import ects_pkg::*;

	localparam int Windows = 1024;
	localparam logic [CfgIdxW-1:0] RegSpareLow  = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpareHigh = 3'd7;
	localparam logic [OpW-1:0]     OpUnused     = 2'd3;

	typedef enum logic { RowWrite, RowRequest } row_kind_e;

	typedef struct {
		logic [ScoreW-1:0] score;
		logic [IndexW-1:0] idx_a;
		logic [IndexW-1:0] idx_b;
		logic [TimeW-1:0]  time_a;
		logic [TimeW-1:0]  time_b;
		logic [CompW-1:0]  tempo_c;
		logic [CompW-1:0]  key_c;
		logic [CompW-1:0]  energy_c;
	} transition_t;

	typedef struct {
		row_kind_e         kind;
		logic [2:0]        code;
		logic [15:0]       value;
		bit                typed;
		transition_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OpW-1:0] operation = '0;
	logic [EnergyW-1:0] energy = '0;
	logic wr_en = 1'b0;
	logic [CfgIdxW-1:0] wr_index = '0;
	logic [CfgW-1:0] wr_data = '0;
	logic done;
	transition_t got;

	energy_curve_transition_search_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .energy(energy),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .score(got.score), .index_first(got.idx_a), .index_second(got.idx_b),
		.time_first_ms(got.time_a), .time_second_ms(got.time_b),
		.tempo_component(got.tempo_c), .key_component(got.key_c),
		.energy_component(got.energy_c)
	);

	// predictor state
	logic [15:0] curve_a [Windows];
	logic [15:0] curve_b [Windows];
	int unsigned fill_a, fill_b;
	logic [15:0] lo_a, hi_a, lo_b, hi_b;
	logic [15:0] tempo_a = 0, tempo_b = 0, win_a = 0, win_b = 0;
	logic [3:0]  pitch_a = PitchUnknown, pitch_b = PitchUnknown;

	transition_t pending_results[$];
	row_t dir_rows[$];
	int errors = 0;
	int sent_items = 0;
	bit calm = 0;

	initial forever #6 clk = ~clk;

	initial begin
		#100_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint g, input longint w);
		$display("mismatch %s: got %0d want %0d at %0t", what, g, w, $realtime);
		errors++;
	endtask

	function automatic longint unsigned normalize(logic [15:0] v, logic [15:0] mn,
			logic [15:0] mx);
		if (mx <= mn || v < mn) return 0;
		return (longint'(v - mn) * 32768) / longint'(mx - mn);
	endfunction

	function automatic logic [CompW-1:0] tempo_match(logic [15:0] a, logic [15:0] b);
		longint unsigned d, s;
		if (a == 0 || b == 0) return QHalf;
		d = (a > b) ? longint'(a - b) : longint'(b - a);
		s = longint'(a) + longint'(b);
		if (200 * d <= 3 * s) return TempoTier0;
		if (200 * d <= 6 * s) return TempoTier1;
		if (200 * d <= 10 * s) return TempoTier2;
		return TempoTier3;
	endfunction

	function automatic logic [CompW-1:0] key_match(logic [3:0] a, logic [3:0] b);
		int d;
		if (a > 11 || b > 11) return QHalf;
		d = (a > b) ? int'(a - b) : int'(b - a);
		case (d)
			0: return KeySame;
			5, 7: return KeyFifth;
			3, 9: return KeyThird;
			6: return KeyTritone;
			1, 11: return KeyStep;
			default: return KeyOther;
		endcase
	endfunction

	function automatic transition_t best_transition();
		transition_t r;
		longint unsigned nb [Windows];
		longint unsigned rb [Windows];
		longint unsigned best, s, cur, prev, fall, low, ec, sc, sum;
		int unsigned bi, bj;
		r = '{default: '0};
		if (fill_a == 0 || fill_b == 0 || win_a == 0 || win_b == 0) return r;
		best = 0; bi = 0; bj = 0; prev = 0;
		for (int j = 0; j < fill_b; j++) begin
			nb[j] = normalize(curve_b[j], lo_b, hi_b);
			rb[j] = (j > 0 && nb[j] > nb[j-1]) ? nb[j] - nb[j-1] : 0;
		end
		for (int i = 0; i < fill_a; i++) begin
			cur = normalize(curve_a[i], lo_a, hi_a);
			fall = (i > 0 && prev > cur) ? prev - cur : 0;
			low = 32768 - cur;
			for (int j = 0; j < fill_b; j++) begin
				s = 3 * (low * nb[j]) + 2 * (fall * rb[j]);
				if (s > best) begin
					best = s; bi = i; bj = j;
				end
			end
			prev = cur;
		end
		ec = (best + 5 * 16384) / (5 * 32768);
		if (ec > 32768) ec = 32768;
		r.tempo_c = tempo_match(tempo_a, tempo_b);
		r.key_c = key_match(pitch_a, pitch_b);
		r.energy_c = CompW'(ec);
		sum = 4 * longint'(r.tempo_c) + 3 * longint'(r.key_c) + 3 * ec;
		sc = (sum * 1000 + 16384) >> 15;
		r.score = (sc > 10000) ? ScoreMax : ScoreW'(sc);
		r.idx_a = IndexW'(bi);
		r.idx_b = IndexW'(bj);
		r.time_a = TimeW'(longint'(bi) * win_a);
		r.time_b = TimeW'(longint'(bj) * win_b);
		return r;
	endfunction

	task automatic store_sample(input logic [OpW-1:0] op, input logic [15:0] v);
		if (op == OpLoadFirst && fill_a < Windows) begin
			if (fill_a == 0) begin lo_a = v; hi_a = v; end
			else begin
				if (v < lo_a) lo_a = v;
				if (v > hi_a) hi_a = v;
			end
			curve_a[fill_a++] = v;
		end else if (op == OpLoadSecond && fill_b < Windows) begin
			if (fill_b == 0) begin lo_b = v; hi_b = v; end
			else begin
				if (v < lo_b) lo_b = v;
				if (v > hi_b) hi_b = v;
			end
			curve_b[fill_b++] = v;
		end
	endtask

	function automatic int gap_len();
		int p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// caller is at a falling edge; returns at a falling edge
	task automatic send_request(input logic [OpW-1:0] op, input logic [15:0] v,
			input bit typed, input transition_t want);
		start = 1'b1;
		operation = op;
		energy = v;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sent_items++;
		if (op == OpEvaluate) begin
			pending_results.push_back(typed ? want : best_transition());
			fill_a = 0;
			fill_b = 0;
		end else store_sample(op, v);
		@(negedge clk);
		start = 1'b0;
		operation = OpW'($urandom);
		energy = EnergyW'($urandom);
		repeat (gap_len()) @(negedge clk);
	endtask

	task automatic request(input logic [OpW-1:0] op, input logic [15:0] v);
		send_request(op, v, 1'b0, '{default: '0});
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] v);
		drain();
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = v;
		case (idx)
			RegTempoFirst: tempo_a = v;
			RegTempoSecond: tempo_b = v;
			RegPitchFirst: pitch_a = v[3:0];
			RegPitchSecond: pitch_b = v[3:0];
			RegWindowFirst: win_a = v;
			RegWindowSecond: win_b = v;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
		wr_data = CfgW'($urandom);
	endtask

	function automatic logic [15:0] pick_energy(logic [15:0] base);
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 16'($urandom);
		if (p < 55) return 16'h0000;
		if (p < 65) return 16'hFFFF;
		return 16'(base + $urandom_range(0, 3));
	endfunction

	function automatic logic [15:0] pick_wide(int zero_pct);
		int p;
		p = $urandom_range(0, 99);
		if (p < zero_pct) return 16'h0000;
		if (p < zero_pct + 10) return 16'hFFFF;
		if (p < zero_pct + 20) return 16'($urandom_range(1, 4));
		return 16'($urandom);
	endfunction

	task automatic random_setting();
		logic [15:0] t;
		t = pick_wide(10);
		write_reg(RegTempoFirst, t);
		if ($urandom_range(0, 1))
			t = 16'(t + $urandom_range(0, 1) * (t / 30) + $urandom_range(0, 60));
		else t = pick_wide(10);
		write_reg(RegTempoSecond, t);
		write_reg(RegPitchFirst, {12'($urandom), 4'($urandom_range(0, 15))});
		write_reg(RegPitchSecond, {12'($urandom), 4'($urandom_range(0, 15))});
		write_reg(RegWindowFirst, pick_wide(8));
		write_reg(RegWindowSecond, pick_wide(8));
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? RegSpareLow : RegSpareHigh, 16'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result count", 1, 0);
			end else begin
				transition_t w;
				w = pending_results.pop_front();
				if (got.score != w.score) report_mismatch("score", got.score, w.score);
				if (got.idx_a != w.idx_a) report_mismatch("index_first", got.idx_a, w.idx_a);
				if (got.idx_b != w.idx_b) report_mismatch("index_second", got.idx_b, w.idx_b);
				if (got.time_a != w.time_a) report_mismatch("time_first", got.time_a, w.time_a);
				if (got.time_b != w.time_b) report_mismatch("time_second", got.time_b, w.time_b);
				if (got.tempo_c != w.tempo_c) report_mismatch("tempo", got.tempo_c, w.tempo_c);
				if (got.key_c != w.key_c) report_mismatch("key", got.key_c, w.key_c);
				if (got.energy_c != w.energy_c)
					report_mismatch("energy", got.energy_c, w.energy_c);
			end
		end
	end

	initial begin
		transition_t none, flat;
		int na, nb;
		logic [15:0] base;
		none = '{default: '0};
		flat = '{score: 14'd7000, tempo_c: QOne, key_c: QOne, default: '0};
		fill_a = 0;
		fill_b = 0;

		dir_rows.push_back('{RowRequest, OpEvaluate, 16'h0, 1'b1, none});
		dir_rows.push_back('{RowWrite, RegWindowFirst, 16'd100, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegWindowSecond, 16'd200, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegTempoFirst, 16'd12000, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegTempoSecond, 16'd12000, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegPitchFirst, 16'd0, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegPitchSecond, 16'd0, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'h0000, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'hFFFF, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadSecond, 16'h0000, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadSecond, 16'hFFFF, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpEvaluate, 16'hFFFF, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'd5, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'd5, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadSecond, 16'd7, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpEvaluate, 16'h0, 1'b1, flat});
		dir_rows.push_back('{RowWrite, RegTempoFirst, 16'd0, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegPitchFirst, 16'hFFF0 | PitchUnknown, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'hFFFF, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpUnused, 16'hFFFF, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'h0000, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadSecond, 16'h0000, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadSecond, 16'hFFFF, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpEvaluate, 16'h0, 1'b0, none});
		dir_rows.push_back('{RowWrite, RegWindowSecond, 16'd0, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadFirst, 16'd1, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpLoadSecond, 16'd1, 1'b0, none});
		dir_rows.push_back('{RowRequest, OpEvaluate, 16'h0, 1'b1, none});

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == RowWrite) write_reg(dir_rows[k].code, dir_rows[k].value);
			else send_request(dir_rows[k].code[OpW-1:0], dir_rows[k].value,
					dir_rows[k].typed, dir_rows[k].want);
		end

		// full store: overflow samples dropped, wide window
		write_reg(RegWindowFirst, 16'hFFFF);
		write_reg(RegWindowSecond, 16'hFFFF);
		write_reg(RegPitchSecond, 16'd11);
		write_reg(RegPitchFirst, 16'd0);
		calm = 1;
		for (int k = 0; k < Windows + 6; k++)
			request(OpLoadFirst, (k < Windows) ? 16'(Windows - k) : 16'h0000);
		request(OpLoadSecond, 16'd3);
		request(OpLoadSecond, 16'd9);
		request(OpEvaluate, 16'h0);
		calm = 0;

		while (sent_items < 1800) begin
			random_setting();
			repeat ($urandom_range(3, 6)) begin
				calm = ($urandom_range(0, 3) == 0);
				base = 16'($urandom);
				if ($urandom_range(0, 99) < 85) begin
					na = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
					nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
					while (na + nb > 0) begin
						if ($urandom_range(0, 99) < 6) request(OpUnused, 16'($urandom));
						if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
							request(OpLoadFirst, pick_energy(base));
							na--;
						end else begin
							request(OpLoadSecond, pick_energy(base));
							nb--;
						end
					end
					request(OpEvaluate, 16'($urandom));
				end else begin
					repeat ($urandom_range(1, 10)) begin
						request(OpW'($urandom_range(0, 3)), pick_energy(base));
					end
				end
			end
			calm = 0;
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
